[rtl/pra_pkg.sv]
package pra_pkg;

  localparam int NUM_TABLES      = 16;
  localparam int PAGES_PER_TABLE = 1024;
  localparam int TOTAL_PAGES     = NUM_TABLES * PAGES_PER_TABLE;

  localparam int PAGE_W  = 14;
  localparam int TBL_W   = $clog2(NUM_TABLES);
  localparam int TCNT_W  = 5;
  localparam int IDX_W   = $clog2(PAGES_PER_TABLE);
  localparam int FRAME_W = 20;
  localparam int CNT_W   = 15;
  localparam int ENTRY_W = 22;

  localparam int ALLOC_BIT   = 20;
  localparam int PRESENT_BIT = 21;

  typedef enum logic [2:0] {
    CMD_SEARCH_MAP = 3'd0,
    CMD_MAP_AT     = 3'd1,
    CMD_UNMAP      = 3'd2,
    CMD_ALLOC      = 3'd3,
    CMD_FREE       = 3'd4
  } cmd_t;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_STBL = 6'b000010,
    ST_SCHK = 6'b000100,
    ST_WCHK = 6'b001000,
    ST_WWR  = 6'b010000,
    ST_CLR  = 6'b100000
  } state_t;

endpackage

[rtl/pra_ram.sv]
module pra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/page_run_allocator_core.sv]
// A search checks each page of a present table in turn and counts an absent table as a
// whole free run; a range write reads each page and writes it back, and first clears every
// entry of each absent table that it creates; unmap and free skip pages of an absent table.
// The result strobe is registered and rises in the cycle after the last step; throughput
// is one request at a time. The receiver cannot stall.
// Reset clears the table present bits and loads high_start with 12; no sweep.
module page_run_allocator_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [2:0]                   cmd,
  input  logic [pra_pkg::PAGE_W-1:0]   page_addr,
  input  logic [pra_pkg::FRAME_W-1:0]  frame,
  input  logic [pra_pkg::CNT_W-1:0]    count,
  input  logic                         high_half,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [4:0]                   cfg_data,
  output logic                         done,
  output logic                         status,
  output logic [pra_pkg::PAGE_W-1:0]   result_page
);

  pra_pkg::state_t state;

  logic [4:0]                      high_start;
  logic [pra_pkg::NUM_TABLES-1:0]  tbl_present;
  logic [2:0]                      op;
  logic [pra_pkg::FRAME_W-1:0]     frm;
  logic [pra_pkg::CNT_W-1:0]       n;
  logic [pra_pkg::CNT_W-1:0]       rem;
  logic [pra_pkg::CNT_W-1:0]       cur;
  logic [pra_pkg::CNT_W-1:0]       run;
  logic [pra_pkg::PAGE_W-1:0]      first;
  logic [pra_pkg::TCNT_W-1:0]      t;
  logic [pra_pkg::TCNT_W-1:0]      t1;
  logic [pra_pkg::IDX_W-1:0]       j;
  logic [pra_pkg::IDX_W-1:0]       clr;

  logic                            mem_we;
  logic [pra_pkg::PAGE_W-1:0]      mem_waddr;
  logic [pra_pkg::ENTRY_W-1:0]     mem_wdata;
  logic [pra_pkg::PAGE_W-1:0]      mem_raddr;
  logic [pra_pkg::ENTRY_W-1:0]     mem_rdata;

  logic [pra_pkg::TCNT_W-1:0]      h_sat;
  logic [pra_pkg::TBL_W-1:0]       wtbl;
  logic                            ent_used;
  logic [pra_pkg::CNT_W-1:0]       run_chk;
  logic [pra_pkg::CNT_W:0]         run_tbl;
  logic [pra_pkg::PAGE_W-1:0]      spage;
  logic                            creates;
  logic                            w_end;

  assign busy      = (state != pra_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;

  assign h_sat    = (high_start > pra_pkg::TCNT_W'(pra_pkg::NUM_TABLES)) ?
                    pra_pkg::TCNT_W'(pra_pkg::NUM_TABLES) : high_start;
  assign wtbl     = cur[pra_pkg::PAGE_W-1:pra_pkg::IDX_W];
  assign ent_used = mem_rdata[pra_pkg::PRESENT_BIT] | mem_rdata[pra_pkg::ALLOC_BIT];
  assign run_chk  = ent_used ? '0 : run + pra_pkg::CNT_W'(1);
  assign run_tbl  = {1'b0, run} + (pra_pkg::CNT_W+1)'(pra_pkg::PAGES_PER_TABLE);
  assign spage    = {t[pra_pkg::TBL_W-1:0], j};
  assign creates  = (op == pra_pkg::CMD_SEARCH_MAP) || (op == pra_pkg::CMD_MAP_AT) ||
                    (op == pra_pkg::CMD_ALLOC);
  assign w_end    = (rem == '0) || (cur >= pra_pkg::CNT_W'(pra_pkg::TOTAL_PAGES));

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cur[pra_pkg::PAGE_W-1:0];
    mem_wdata = '0;
    mem_raddr = cur[pra_pkg::PAGE_W-1:0];
    case (state)
      pra_pkg::ST_STBL: begin
        mem_raddr = {t[pra_pkg::TBL_W-1:0], pra_pkg::IDX_W'(0)};
      end
      pra_pkg::ST_SCHK: begin
        mem_raddr = {t[pra_pkg::TBL_W-1:0], j + pra_pkg::IDX_W'(1)};
      end
      pra_pkg::ST_WWR: begin
        mem_we = 1'b1;
        case (op)
          pra_pkg::CMD_SEARCH_MAP, pra_pkg::CMD_MAP_AT: begin
            mem_wdata = {1'b1, mem_rdata[pra_pkg::ALLOC_BIT], frm};
          end
          pra_pkg::CMD_ALLOC: begin
            mem_wdata = {2'b01, pra_pkg::FRAME_W'(0)};
          end
          pra_pkg::CMD_UNMAP: begin
            mem_wdata = {1'b0, mem_rdata[pra_pkg::PRESENT_BIT-1:0]};
          end
          default: begin
            mem_wdata = '0;
          end
        endcase
      end
      pra_pkg::ST_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = {wtbl, clr};
      end
      default: begin
      end
    endcase
  end

  pra_ram #(
    .WIDTH (pra_pkg::ENTRY_W),
    .DEPTH (pra_pkg::TOTAL_PAGES)
  ) u_entries (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      high_start  <= 5'd12;
    end else if (cfg_valid && cfg_ready) begin
      high_start  <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= pra_pkg::ST_IDLE;
      tbl_present <= '0;
      done        <= 1'b0;
      status      <= 1'b0;
      result_page <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        pra_pkg::ST_IDLE: begin
          if (start) begin
            op     <= cmd;
            frm    <= frame;
            n      <= count;
            status <= 1'b0;
            case (cmd)
              pra_pkg::CMD_SEARCH_MAP, pra_pkg::CMD_ALLOC: begin
                result_page <= '0;
                if (count == '0) begin
                  done <= 1'b1;
                end else begin
                  t     <= high_half ? h_sat : '0;
                  t1    <= high_half ? pra_pkg::TCNT_W'(pra_pkg::NUM_TABLES) : h_sat;
                  run   <= '0;
                  first <= '0;
                  state <= pra_pkg::ST_STBL;
                end
              end
              pra_pkg::CMD_MAP_AT, pra_pkg::CMD_UNMAP, pra_pkg::CMD_FREE: begin
                result_page <= page_addr;
                cur         <= {1'b0, page_addr};
                rem         <= count;
                state       <= pra_pkg::ST_WCHK;
              end
              default: begin
                result_page <= '0;
                done        <= 1'b1;
              end
            endcase
          end
        end
        pra_pkg::ST_STBL: begin
          if (t >= t1) begin
            status <= 1'b1;
            done   <= 1'b1;
            state  <= pra_pkg::ST_IDLE;
          end else if (!tbl_present[t[pra_pkg::TBL_W-1:0]]) begin
            if (run == '0) begin
              first <= {t[pra_pkg::TBL_W-1:0], pra_pkg::IDX_W'(0)};
            end
            if (run_tbl >= {1'b0, n}) begin
              result_page <= (run == '0) ? {t[pra_pkg::TBL_W-1:0], pra_pkg::IDX_W'(0)}
                                         : first;
              cur         <= (run == '0) ? {1'b0, t[pra_pkg::TBL_W-1:0],
                                            pra_pkg::IDX_W'(0)} : {1'b0, first};
              rem         <= n;
              state       <= pra_pkg::ST_WCHK;
            end else begin
              run <= run_tbl[pra_pkg::CNT_W-1:0];
              t   <= t + pra_pkg::TCNT_W'(1);
            end
          end else begin
            j     <= '0;
            state <= pra_pkg::ST_SCHK;
          end
        end
        pra_pkg::ST_SCHK: begin
          run <= run_chk;
          if (!ent_used && run == '0) begin
            first <= spage;
          end
          if (run_chk >= n) begin
            result_page <= (run == '0) ? spage : first;
            cur         <= (run == '0) ? {1'b0, spage} : {1'b0, first};
            rem         <= n;
            state       <= pra_pkg::ST_WCHK;
          end else if (j == pra_pkg::IDX_W'(pra_pkg::PAGES_PER_TABLE - 1)) begin
            t     <= t + pra_pkg::TCNT_W'(1);
            state <= pra_pkg::ST_STBL;
          end else begin
            j <= j + pra_pkg::IDX_W'(1);
          end
        end
        pra_pkg::ST_WCHK: begin
          if (w_end) begin
            done  <= 1'b1;
            state <= pra_pkg::ST_IDLE;
          end else if (!tbl_present[wtbl]) begin
            if (creates) begin
              clr   <= '0;
              state <= pra_pkg::ST_CLR;
            end else begin
              cur <= cur + pra_pkg::CNT_W'(1);
              rem <= rem - pra_pkg::CNT_W'(1);
            end
          end else begin
            state <= pra_pkg::ST_WWR;
          end
        end
        pra_pkg::ST_WWR: begin
          cur   <= cur + pra_pkg::CNT_W'(1);
          rem   <= rem - pra_pkg::CNT_W'(1);
          frm   <= frm + pra_pkg::FRAME_W'(1);
          state <= pra_pkg::ST_WCHK;
        end
        pra_pkg::ST_CLR: begin
          clr <= clr + pra_pkg::IDX_W'(1);
          if (clr == pra_pkg::IDX_W'(pra_pkg::PAGES_PER_TABLE - 1)) begin
            tbl_present[wtbl] <= 1'b1;
            state             <= pra_pkg::ST_WCHK;
          end
        end
        default: begin
          state <= pra_pkg::ST_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state != pra_pkg::ST_IDLE) || $past(start))
    else $error("result strobe without a request");
  a_fail_page_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status) |-> (result_page == '0))
    else $error("failed search reports a nonzero page");
  a_write_states: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == pra_pkg::ST_WWR || state == pra_pkg::ST_CLR))
    else $error("entry write outside the write phase");
  a_walk_present: assert property (@(posedge clk) disable iff (rst)
    (state == pra_pkg::ST_SCHK) |-> tbl_present[t[pra_pkg::TBL_W-1:0]])
    else $error("page walk in an absent table");
  a_wr_present: assert property (@(posedge clk) disable iff (rst)
    (state == pra_pkg::ST_WWR) |-> tbl_present[wtbl])
    else $error("entry update in an absent table");
`endif

endmodule
